// ===== rtl/pas_pkg.sv =====
`default_nettype none

package pas_pkg;

    localparam int DIV_STEPS = 34;              // quotient bits, enough to reach the clamp
    localparam int DIV_LAT   = DIV_STEPS + 1;   // overflow check stage plus one stage a bit
    localparam int HEAD_LAT  = 3;               // delta, products, distance sum
    localparam int TAIL_LAT  = 3;               // add, friction, position

    localparam logic [31:0] DEADZONE_RST = 32'd1;
    localparam logic [31:0] STRENGTH_RST = 32'd65536;
    localparam logic [15:0] FRICTION_RST = 16'd64880;

    localparam logic [33:0] DV_CLAMP = 34'h2_0000_0000;

    typedef enum logic [1:0] {
        CFG_DEADZONE = 2'd0,
        CFG_STRENGTH = 2'd1,
        CFG_FRICTION = 2'd2,
        CFG_SPARE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               neg_x;
        logic               neg_y;
        logic               attract;
    } t_side;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [35:0] v);
        t_sat s;
        s.clip = 1'b0;
        s.val  = v[31:0];
        if (v > 36'sh0_7FFF_FFFF) begin
            s.clip = 1'b1;
            s.val  = 32'sh7FFF_FFFF;
        end else if (v < -36'sh0_8000_0000) begin
            s.clip = 1'b1;
            s.val  = 32'sh8000_0000;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pas_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per stage, top bit first.
module pas_div import pas_pkg::*; (
    input  wire         i_clk,
    input  wire         i_en,
    input  wire  [63:0] i_num,
    input  wire  [48:0] i_dsq,
    output logic [33:0] o_q,
    output logic        o_ovf
);

    logic [63:0] r_rem [0:DIV_STEPS-1];
    logic [48:0] r_dsq [0:DIV_STEPS-1];
    logic [33:0] r_q   [0:DIV_STEPS];
    logic        r_ovf [0:DIV_STEPS];

    // quotient of 2^34 or more: clamp regardless
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_dsq[0] <= i_dsq;
            r_q[0]   <= '0;
            r_ovf[0] <= (i_num >> DIV_STEPS) >= {15'd0, i_dsq};
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [83:0] dsh, rext, diff;
        logic        ge;

        assign dsh  = {35'd0, r_dsq[k]} << (DIV_STEPS - 1 - k);
        assign rext = {20'd0, r_rem[k]};
        assign ge   = rext >= dsh;
        assign diff = rext - dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]   <= {r_q[k][32:0], ge};
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        if (k < DIV_STEPS - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= ge ? diff[63:0] : r_rem[k];
                    r_dsq[k+1] <= r_dsq[k];
                end
            end
        end
    end

    assign o_q   = r_q[DIV_STEPS];
    assign o_ovf = r_ovf[DIV_STEPS];

endmodule

`default_nettype wire

// ===== rtl/pas_axis.sv =====
`default_nettype none

// Per-axis tail: velocity kick, friction, position update. Three stages.
module pas_axis import pas_pkg::*; (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire         [15:0] i_friction,
    input  wire  signed [31:0] i_pos,
    input  wire  signed [31:0] i_vel,
    input  wire                i_neg,
    input  wire                i_attract,
    input  wire         [33:0] i_q,
    input  wire                i_ovf,
    output logic signed [31:0] o_pos,
    output logic signed [31:0] o_vel,
    output logic               o_clip
);

    logic [33:0]        dv;
    logic signed [35:0] sum;
    t_sat               s1, s3;
    logic signed [48:0] prod, prod_rnd;
    logic signed [31:0] v2;

    logic signed [31:0] r_v1, r_v2, r_pos1, r_pos2;
    logic               r_c1, r_c2;

    always_comb begin
        dv = (i_ovf || i_q > DV_CLAMP) ? DV_CLAMP : i_q;
        if (!i_attract) begin
            sum = 36'(i_vel);
        end else if (i_neg) begin
            sum = 36'(i_vel) - $signed({2'b00, dv});
        end else begin
            sum = 36'(i_vel) + $signed({2'b00, dv});
        end
        s1 = sat32(sum);
    end

    // truncate toward zero: bias negatives before the shift
    always_comb begin
        prod     = 49'(r_v1) * $signed({33'd0, i_friction});
        prod_rnd = prod + (prod[48] ? 49'sd65535 : 49'sd0);
        v2       = prod_rnd[47:16];
        s3       = sat32(36'(r_pos2) + 36'(r_v2));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1   <= s1.val;
            r_c1   <= s1.clip;
            r_pos1 <= i_pos;
            r_v2   <= v2;
            r_c2   <= r_c1;
            r_pos2 <= r_pos1;
            o_vel  <= r_v2;
            o_pos  <= s3.val;
            o_clip <= r_c2 | s3.clip;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/particle_attractor_step_unit.sv =====
`default_nettype none

// Particle attractor step: advances one particle by one tick in signed Q16.16.
// Fully pipelined, one particle per cycle unless the output stalls: three head stages
// (delta, squares and gain products, squared distance), a 35-stage restoring
// divider per axis (an overflow check plus one quotient bit per stage) and a
// three-stage tail (velocity kick with saturation, friction multiply, position
// update). The whole pipe advances together; it holds only when the result
// register is full and stalled, so a stall on the output reaches o_in_stall in
// the same cycle. Configuration takes effect on items accepted after the write
// and should only be written with the pipe empty. o_cfg_ready is always high.
module particle_attractor_step_unit import pas_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,

    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire          [1:0] i_cfg_index,
    input  wire         [31:0] i_cfg_data,

    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire         [15:0] i_particle_id,
    input  wire  signed [31:0] i_pos_x,
    input  wire  signed [31:0] i_pos_y,
    input  wire  signed [31:0] i_vel_x,
    input  wire  signed [31:0] i_vel_y,
    input  wire  signed [15:0] i_target_x,
    input  wire  signed [15:0] i_target_y,

    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic        [15:0] o_out_particle_id,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic               o_saturated
);

    localparam int NSTG = HEAD_LAT + DIV_LAT + TAIL_LAT;

    // ---- configuration registers
    logic [31:0] r_deadzone, r_strength;
    logic [15:0] r_friction;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DEADZONE_RST;
            r_strength <= STRENGTH_RST;
            r_friction <= FRICTION_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEADZONE: r_deadzone <= i_cfg_data;
                CFG_STRENGTH: r_strength <= i_cfg_data;
                CFG_FRICTION: r_friction <= i_cfg_data[15:0];
                default: ;  // spare index, ignored
            endcase
        end
    end

    // ---- pipeline control: one enable for every stage
    logic            r_vld [0:NSTG-1];
    logic            en;

    assign en          = !(r_vld[NSTG-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---- stage 1: delta to target, as magnitude and sign (|d| < 2^32)
    logic signed [32:0] dx, dy;
    logic        [32:0] ax, ay;
    t_side              r_s1, r_s2, r_s3;
    logic        [31:0] r_mx, r_my;

    always_comb begin
        dx = $signed({i_target_x[15], i_target_x, 16'd0}) - 33'(i_pos_x);
        dy = $signed({i_target_y[15], i_target_y, 16'd0}) - 33'(i_pos_y);
        ax = dx[32] ? -dx : dx;
        ay = dy[32] ? -dy : dy;
    end

    // ---- stage 2: squares in Q16.16 and gain products
    logic [63:0] sqx_full, sqy_full;
    logic [47:0] r_sqx, r_sqy;
    logic [63:0] r_numx2, r_numy2;

    assign sqx_full = r_mx * r_mx;
    assign sqy_full = r_my * r_my;

    // ---- stage 3: squared distance and deadzone test
    logic [48:0] dsq;
    logic [48:0] r_dsq;
    logic [63:0] r_numx, r_numy;
    t_side       n_s3;

    assign dsq = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_comb begin
        n_s3         = r_s2;
        n_s3.attract = dsq > {1'b0, r_deadzone, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1         <= '{id: i_particle_id, pos_x: i_pos_x, pos_y: i_pos_y,
                              vel_x: i_vel_x, vel_y: i_vel_y, neg_x: dx[32],
                              neg_y: dy[32], attract: 1'b0};
            r_mx         <= ax[31:0];
            r_my         <= ay[31:0];
            r_s2         <= r_s1;
            r_sqx        <= sqx_full[63:16];
            r_sqy        <= sqy_full[63:16];
            r_numx2      <= r_mx * r_strength;
            r_numy2      <= r_my * r_strength;
            r_s3         <= n_s3;
            r_dsq        <= dsq;
            r_numx       <= r_numx2;
            r_numy       <= r_numy2;
        end
    end

    // ---- dividers, side data runs alongside
    logic [33:0] qx, qy;
    logic        ovfx, ovfy;
    t_side       r_side [0:DIV_LAT-1];

    pas_div u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_numx), .i_dsq(r_dsq), .o_q(qx), .o_ovf(ovfx)
    );
    pas_div u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_numy), .i_dsq(r_dsq), .o_q(qy), .o_ovf(ovfy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_s3;
            for (int k = 1; k < DIV_LAT; k++) r_side[k] <= r_side[k-1];
        end
    end

    // ---- tail: kick, friction, position; final stage is the result register
    t_side       sd;
    logic        clipx, clipy;
    logic [15:0] r_id [0:TAIL_LAT-1];

    assign sd = r_side[DIV_LAT-1];

    pas_axis u_axis_x (
        .i_clk(i_clk), .i_en(en), .i_friction(r_friction),
        .i_pos(sd.pos_x), .i_vel(sd.vel_x), .i_neg(sd.neg_x), .i_attract(sd.attract),
        .i_q(qx), .i_ovf(ovfx),
        .o_pos(o_new_pos_x), .o_vel(o_new_vel_x), .o_clip(clipx)
    );
    pas_axis u_axis_y (
        .i_clk(i_clk), .i_en(en), .i_friction(r_friction),
        .i_pos(sd.pos_y), .i_vel(sd.vel_y), .i_neg(sd.neg_y), .i_attract(sd.attract),
        .i_q(qy), .i_ovf(ovfy),
        .o_pos(o_new_pos_y), .o_vel(o_new_vel_y), .o_clip(clipy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_id[0] <= sd.id;
            for (int k = 1; k < TAIL_LAT; k++) r_id[k] <= r_id[k-1];
        end
    end

    assign o_out_particle_id = r_id[TAIL_LAT-1];
    assign o_saturated       = clipx | clipy;

    // ---- checks
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("output stall not pushed back to input");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[NSTG-2]) |=> o_out_valid)
        else $error("transaction lost in last stage");

endmodule

`default_nettype wire

// ===== sim/pas_checker.sv =====
`timescale 1ns / 1ps

// Watches the input, config and output channels, predicts each particle step
// and compares against the results in order.
module pas_checker import pas_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_valid,
    input  wire                i_cfg_ready,
    input  wire          [1:0] i_cfg_index,
    input  wire         [31:0] i_cfg_data,
    input  wire                i_in_valid,
    input  wire                i_in_stall,
    input  wire         [15:0] i_particle_id,
    input  wire  signed [31:0] i_pos_x,
    input  wire  signed [31:0] i_pos_y,
    input  wire  signed [31:0] i_vel_x,
    input  wire  signed [31:0] i_vel_y,
    input  wire  signed [15:0] i_target_x,
    input  wire  signed [15:0] i_target_y,
    input  wire                i_out_valid,
    input  wire                i_out_stall,
    input  wire         [15:0] i_out_particle_id,
    input  wire  signed [31:0] i_new_pos_x,
    input  wire  signed [31:0] i_new_pos_y,
    input  wire  signed [31:0] i_new_vel_x,
    input  wire  signed [31:0] i_new_vel_y,
    input  wire                i_saturated,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        sat;
    } t_step;

    logic [31:0] deadzone_q, strength_q;
    logic [15:0] friction_q;
    t_step       step_q[$];

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v,
                                                  inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // One axis: kick, friction, position update
    function automatic void advance_axis(input logic signed [63:0] pos, vel, d,
                                         input logic attract, input logic [63:0] dsq,
                                         output logic [31:0] npos, nvel,
                                         inout logic flag);
        logic signed [63:0] v1, p, v2, pn;
        logic [63:0] dv, pm;
        v1 = vel;
        if (attract) begin
            dv = (magnitude(d) * {32'd0, strength_q}) / dsq;
            if (dv > 64'h2_0000_0000) dv = 64'h2_0000_0000;
            v1 = d < 0 ? vel - $signed(dv) : vel + $signed(dv);
            v1 = clip32(v1, flag);
        end
        p  = v1 * $signed({48'd0, friction_q});
        pm = magnitude(p) >> 16;
        v2 = p < 0 ? -$signed(pm) : $signed(pm);
        nvel = v2[31:0];
        pn   = clip32(pos + v2, flag);
        npos = pn[31:0];
    endfunction

    function automatic t_step predict_step();
        t_step r;
        logic signed [63:0] px, py, dx, dy;
        logic [63:0] dsq, mx, my;
        logic flag, att;
        px  = i_pos_x;
        py  = i_pos_y;
        dx  = ($signed(64'(i_target_x)) <<< 16) - px;
        dy  = ($signed(64'(i_target_y)) <<< 16) - py;
        mx  = magnitude(dx);
        my  = magnitude(dy);
        dsq = ((mx * mx) >> 16) + ((my * my) >> 16);
        att = dsq > ({32'd0, deadzone_q} << 16);
        flag = 1'b0;
        advance_axis(px, 64'(i_vel_x), dx, att, dsq, r.px, r.vx, flag);
        advance_axis(py, 64'(i_vel_y), dy, att, dsq, r.py, r.vy, flag);
        r.id  = i_particle_id;
        r.sat = flag;
        return r;
    endfunction

    assign o_pending = step_q.size();

    always @(posedge i_clk) begin
        t_step e;
        if (!i_rst_n) begin
            deadzone_q   <= DEADZONE_RST;
            strength_q   <= STRENGTH_RST;
            friction_q   <= FRICTION_RST;
            o_fail_count <= 0;
            step_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DEADZONE: deadzone_q <= i_cfg_data;
                    CFG_STRENGTH: strength_q <= i_cfg_data;
                    CFG_FRICTION: friction_q <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                step_q.push_back(predict_step());
            if (i_out_valid && !i_out_stall) begin
                if (step_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("checker: result with nothing expected, id %0d",
                                 i_out_particle_id);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = step_q.pop_front();
                    if (e != {i_out_particle_id, i_new_pos_x, i_new_pos_y,
                              i_new_vel_x, i_new_vel_y, i_saturated}) begin
                        if (o_fail_count < 10)
                            $display({"checker: mismatch exp id %h p %h %h v %h %h s %b,",
                                      " got id %h p %h %h v %h %h s %b"},
                                     e.id, e.px, e.py, e.vx, e.vy, e.sat,
                                     i_out_particle_id, i_new_pos_x, i_new_pos_y,
                                     i_new_vel_x, i_new_vel_y, i_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the particle step unit. The checker beside the
// block does all prediction and comparison; here we only drive transactions.
module tb;
    import pas_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 60;     // a little beyond the pipe depth

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    wire                cfg_ready;
    logic         [1:0] cfg_index = '0;
    logic        [31:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    wire                in_stall;
    logic        [15:0] particle_id = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
    logic signed [15:0] target_x = '0, target_y = '0;
    wire                out_valid;
    logic               out_stall = 1'b0;
    wire         [15:0] out_id;
    wire  signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
    wire                saturated;
    int                 fail_count, pending;
    int                 cycles = 0;
    logic               calm = 1'b0;     // no idling near the end

    always #6 clk = ~clk;

    particle_attractor_step_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_particle_id(particle_id), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_target_x(target_x), .i_target_y(target_y),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_particle_id(out_id), .o_new_pos_x(new_pos_x),
        .o_new_pos_y(new_pos_y), .o_new_vel_x(new_vel_x),
        .o_new_vel_y(new_vel_y), .o_saturated(saturated)
    );

    pas_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_particle_id(particle_id), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_target_x(target_x), .i_target_y(target_y),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_particle_id(out_id), .i_new_pos_x(new_pos_x),
        .i_new_pos_y(new_pos_y), .i_new_vel_x(new_vel_x),
        .i_new_vel_y(new_vel_y), .i_saturated(saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stall in random bursts, none once calm
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                // stretch without stalls
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the pipe to empty before touching config
    task automatic drain_pipe();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Drive one particle; valid stays high across back-to-back items
    task automatic send_particle(input logic [15:0] id, input logic [31:0] px, py,
                                 vx, vy, input logic [15:0] tx, ty);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        particle_id <= id;
        pos_x <= px; pos_y <= py; vel_x <= vx; vel_y <= vy;
        target_x <= tx; target_y <= ty;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word(input int kind);
        case (kind)
            0: return $urandom;
            1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< 12;
        endcase
    endfunction

    // Particles near the attractor so the kick path is exercised
    task automatic random_burst(input int count);
        logic [15:0] tx, ty;
        logic [31:0] px, py;
        for (int k = 0; k < count; k++) begin
            tx = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
            ty = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
            if ($urandom_range(0, 3) != 0) begin
                px = {tx, 16'd0} + rand_word(3);
                py = {ty, 16'd0} + rand_word(3);
            end else begin
                px = rand_word($urandom_range(0, 2));
                py = rand_word($urandom_range(0, 2));
            end
            send_particle(16'($urandom), px, py, rand_word($urandom_range(0, 3)),
                          rand_word($urandom_range(0, 3)), tx, ty);
        end
        end_burst();
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset config first
        send_particle(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);      // zero distance
        send_particle(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 16'h8000, 16'h7FFF);                        // extremes
        send_particle(16'h1234, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
        send_particle(16'h0001, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0); // on deadzone
        send_particle(16'h0002, 32'h0, 32'h0, 32'h0010_0000, 32'hFFF0_0000, 16'd5, 16'd3);
        send_particle(16'h0003, 32'h7FFF_0000, 32'h0, 32'h7FFF_0000, 32'h0, 16'h7FFF, 16'h0);
        end_burst();
        drain_pipe();

        // Huge attraction, clamp and saturation
        write_reg(CFG_STRENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_DEADZONE, 32'd0);
        send_particle(16'h0010, 32'h0000_0100, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_particle(16'h0011, 32'h0, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0);
        send_particle(16'h0012, 32'h0, 32'h0, 32'h0, 32'h0, 16'd1, 16'hFFFF);
        end_burst();
        drain_pipe();

        // Zero friction, zero strength, huge deadzone, spare index
        write_reg(CFG_FRICTION, 32'h0);
        write_reg(CFG_SPARE, 32'hDEAD_BEEF);
        send_particle(16'h0020, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 32'h8000_0000,
                      16'd100, 16'hFF00);
        end_burst();
        drain_pipe();
        write_reg(CFG_FRICTION, 32'hFFFF);
        write_reg(CFG_STRENGTH, 32'h0);
        write_reg(CFG_DEADZONE, 32'hFFFF_FFFF);
        send_particle(16'h0021, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      16'h7FFF, 16'h7FFF);
        end_burst();
        drain_pipe();

        // Random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_DEADZONE, ph == 0 ? 32'd0 : 32'($urandom_range(0, 5000)));
            write_reg(CFG_STRENGTH, ph == 1 ? 32'hFFFF_FFFF : 32'($urandom) >> $urandom_range(0, 24));
            write_reg(CFG_FRICTION, ph == 2 ? 32'h0 : 32'($urandom_range(0, 65535)));
            if (ph == 7) calm = 1'b1;
            random_burst(235);
            drain_pipe();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pas_pkg.sv
rtl/pas_div.sv
rtl/pas_axis.sv
rtl/particle_attractor_step_unit.sv
sim/pas_checker.sv
sim/tb.sv
